// ===== hdl/abvs_pkg.sv =====
// shared types and constants for the audio byte volume scaler
package abvs_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned StepW   = 4;
    localparam int unsigned RecipW  = 20;

    // ceil(2^22 / 5), exact quotient for any 18-bit dividend
    localparam logic [RecipW-1:0] RECIP_FIVE = 20'd838861;

    localparam logic [1:0] CFG_SIXTEEN_BIT = 2'd0;
    localparam logic [1:0] CFG_VOLUME_LVL  = 2'd1;
    localparam logic [1:0] CFG_VOLUME_MAX  = 2'd2;
    localparam logic [1:0] CFG_VOLUME_MIN  = 2'd3;

    localparam logic [StepW-1:0] UNITY_EDGE = 4'd4;

    // classified sample handed from front to back
    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic               mode16;
        logic               up;
        logic               err;
        logic [StepW-1:0]   gain;
    } t_item;

endpackage

// ===== hdl/abvs_front.sv =====
// front end: config registers, byte pairing and volume rule classification
module abvs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [3:0]          i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output abvs_pkg::t_item     o_item
);

    logic       r_mode16;
    logic [3:0] r_level;
    logic [3:0] r_max;
    logic [3:0] r_min;
    logic [7:0] r_held;
    logic       r_pending;
    logic       n_pending;
    logic       up;
    logic       down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode16 <= 1'b1;
            r_level  <= 4'd5;
            r_max    <= 4'd9;
            r_min    <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                abvs_pkg::CFG_SIXTEEN_BIT: r_mode16 <= i_cfg_data[0];
                abvs_pkg::CFG_VOLUME_LVL:  r_level  <= i_cfg_data;
                abvs_pkg::CFG_VOLUME_MAX:  r_max    <= i_cfg_data;
                abvs_pkg::CFG_VOLUME_MIN:  r_min    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign up   = (r_level > abvs_pkg::UNITY_EDGE) && (r_level <= r_max);
    assign down = (r_level <= abvs_pkg::UNITY_EDGE) && (r_level > r_min);

    // in 16-bit mode first byte of a pair is held, second completes the sample
    always_comb begin
        n_pending = r_pending;
        o_push    = 1'b0;
        if (i_accept) begin
            if (r_mode16 && !r_pending) begin
                n_pending = 1'b1;
            end else begin
                n_pending = 1'b0;
                o_push    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= 8'd0;
        end else begin
            r_pending <= n_pending;
            if (i_accept && r_mode16 && !r_pending) begin
                r_held <= i_byte;
            end
        end
    end

    always_comb begin
        o_item.sample = r_mode16 ? {i_byte, r_held} : {8'd0, i_byte};
        o_item.mode16 = r_mode16;
        o_item.up     = up;
        o_item.err    = !up && !down;
        o_item.gain   = up ? (r_level - abvs_pkg::UNITY_EDGE) : r_level;
    end

endmodule

// ===== hdl/abvs_queue.sv =====
// small fifo of classified samples between front and back
module abvs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  abvs_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output abvs_pkg::t_item o_item
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    abvs_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/abvs_back.sv =====
// back end: three stage scaling pipeline ending in the output register
module abvs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  abvs_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_sample,
    output logic            o_err
);

    logic        en;
    logic        neg;
    logic [16:0] mag;

    logic        r1_valid;
    logic [20:0] r1_prod;
    logic        r1_neg;
    logic        r1_mode16;
    logic        r1_up;
    logic        r1_err;

    logic        r2_valid;
    logic [20:0] r2_prod;
    logic [15:0] r2_quot;
    logic        r2_neg;
    logic        r2_mode16;
    logic        r2_up;
    logic        r2_err;

    logic [17:0] div_in;
    logic [37:0] div_prod;
    logic        up_sat16n;
    logic        up_sat16p;
    logic        up_sat8;
    logic [15:0] res16;
    logic [6:0]  t7;
    logic [15:0] wide8;
    logic [15:0] res8;
    logic [15:0] n_sample;

    logic        r_valid;
    logic [15:0] r_sample;
    logic        r_err;

    assign en    = !r_valid || i_ready;
    assign o_pop = en;

    // magnitude of the sample in either mode
    always_comb begin
        if (i_item.mode16) begin
            neg = i_item.sample[15];
            mag = neg ? (17'h10000 - {1'b0, i_item.sample}) : {1'b0, i_item.sample};
        end else begin
            neg = !i_item.sample[7];
            mag = neg ? (17'h00080 - {9'd0, i_item.sample[7:0]})
                      : {10'd0, i_item.sample[6:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod   <= {4'd0, mag} * {17'd0, i_item.gain};
            r1_neg    <= neg;
            r1_mode16 <= i_item.mode16;
            r1_up     <= i_item.up;
            r1_err    <= i_item.err;
        end
    end

    // (p + 4) / 5 by reciprocal multiply
    assign div_in   = r1_prod[17:0] + 18'd4;
    assign div_prod = {20'd0, div_in} * {18'd0, abvs_pkg::RECIP_FIVE};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_prod   <= r1_prod;
            r2_quot   <= div_prod[37:22];
            r2_neg    <= r1_neg;
            r2_mode16 <= r1_mode16;
            r2_up     <= r1_up;
            r2_err    <= r1_err;
        end
    end

    always_comb begin
        up_sat16n = (r2_prod > 21'h08000);
        up_sat16p = (r2_prod > 21'h07fff);
        up_sat8   = (r2_prod > 21'h0007f);
        if (r2_up) begin
            if (r2_neg) begin
                res16 = up_sat16n ? 16'h8000 : (~r2_prod[15:0] + 16'd1);
            end else begin
                res16 = up_sat16p ? 16'h7fff : r2_prod[15:0];
            end
        end else begin
            res16 = r2_neg ? (~r2_quot + 16'd1) : r2_quot;
        end
        if (r2_up) begin
            t7 = up_sat8 ? 7'h7f : r2_prod[6:0];
        end else begin
            t7 = r2_quot[6:0];
        end
        // times 258 as two shifts
        wide8 = {1'b0, t7, 8'd0} + {8'd0, t7, 1'b0};
        if (r2_neg) begin
            res8 = (r2_up && up_sat8) ? 16'h8000 : (~wide8 + 16'd1);
        end else begin
            res8 = wide8;
        end
        if (r2_err) begin
            n_sample = 16'd0;
        end else begin
            n_sample = r2_mode16 ? res16 : res8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sample <= n_sample;
            r_err    <= r2_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r_valid  <= r2_valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_err    = r_err;

endmodule

// ===== hdl/audio_byte_volume_scaler_top.sv =====
// top level of the audio byte volume scaler
// a completing byte's word passes the sample fifo, scaling registers r1 and r2 and
//   the output register; throughput: one byte per cycle while the fifo has room;
//   a word every cycle in 8-bit mode, every second byte in 16-bit mode
// the sample fifo lets the front take bytes while the output stalls, until it fills
// reset: synchronous active low; config to defaults, fifo emptied, held byte dropped
module audio_byte_volume_scaler_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_data,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    // word output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] sample_word
    output logic        o_m_tuser    // [0] volume_error
);

    logic            accept;
    logic            push;
    logic            full;
    abvs_pkg::t_item front_item;
    logic            q_valid;
    logic            q_pop;
    abvs_pkg::t_item q_item;

    // accept a byte whenever the fifo has room
    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    // pairing, config and classification
    abvs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_byte     (i_s_tdata),
        .o_push     (push),
        .o_item     (front_item)
    );

    // decoupling fifo between front and back
    abvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // scaling pipeline and output register
    abvs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_sample (o_m_tdata),
        .o_err    (o_m_tuser)
    );

endmodule

// ===== tb/audio_byte_volume_scaler_top_test.sv =====
// self-checking testbench for the audio byte volume scaler top level
module audio_byte_volume_scaler_top_test;

    localparam int unsigned CLK_PERIOD      = 12;
    localparam int unsigned RESET_CYCLES    = 7;
    // the fifo and back end registers hold words in flight; this covers the pipe
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned MAX_IDLE        = 16;
    localparam int unsigned RAND_PHASES     = 21;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned LIMIT_CYCLES    = 400000;

    // one expected output word with its error flag
    typedef struct {
        logic [15:0] word;
        logic        err;
    } t_scaled_word;

    // dut ports; the inputs are driven to known values from time zero
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [3:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] data_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [15:0] sample_word
    logic        o_m_tuser;         // [0] volume_error

    // shadow of the configuration registers
    logic        cfg_mode16 = 1'b1;
    logic [3:0]  cfg_level  = 4'd5;
    logic [3:0]  cfg_max    = 4'd9;
    logic [3:0]  cfg_min    = 4'd0;

    // shadow of the byte pairing state
    logic [7:0]  held_low   = '0;
    logic        low_held   = 1'b0;

    t_scaled_word scaled_word_q[$];
    int unsigned  mismatch_count = 0;

    // idling switches, set per phase; 1 means no gaps on that side
    bit send_steady = 1'b0;
    bit sink_steady = 1'b0;

    audio_byte_volume_scaler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // 16-bit signed sample: amplify saturates, attenuate is ceil(mag*v/5)
    function automatic logic [15:0] scale_wide(logic [15:0] s, logic [3:0] v, logic amp);
        int unsigned d, m, k, t;
        d = 32'(s);
        k = 32'(v);
        if (d >= 32'h8000) begin
            m = 32'h10000 - d;
            if (amp) begin
                t = m * (k - 4);
                t = (t > 32'h8000) ? 32'h8000 : 32'h10000 - t;
            end else begin
                t = 32'h10000 - ((m * k + 4) / 5);
            end
        end else begin
            if (amp) begin
                t = d * (k - 4);
                if (t > 32'h7fff) t = 32'h7fff;
            end else begin
                t = (d * k + 4) / 5;
            end
        end
        return 16'(t);
    endfunction

    // 8-bit offset-binary sample, magnitude widened by 258
    function automatic logic [15:0] scale_narrow(logic [7:0] s, logic [3:0] v, logic amp);
        int unsigned d, m, k, t;
        d = 32'(s);
        k = 32'(v);
        if (d >= 32'h80) begin
            m = d - 32'h80;
            if (amp) begin
                t = m * (k - 4);
                if (t > 32'h7f) t = 32'h7f;
            end else begin
                t = (m * k + 4) / 5;
            end
            t = (t & 32'h7f) * 258;
        end else begin
            m = 32'h80 - d;
            if (amp) begin
                t = m * (k - 4);
                t = (t > 32'h7f) ? 32'd32768 : 32'd65536 - t * 258;
            end else begin
                t = (m * k + 4) / 5;
                t = 32'd65536 - t * 258;
            end
        end
        return 16'(t);
    endfunction

    // advance the pairing state by one accepted byte; 1 when a word results
    function automatic bit predict_word(input logic [7:0] b, output t_scaled_word res);
        logic [15:0] sample;
        logic        amp, att;
        amp = (cfg_level > 4'd4) && (cfg_level <= cfg_max);
        att = (cfg_level <= 4'd4) && (cfg_level > cfg_min);
        res.word = '0;
        res.err  = 1'b0;
        if (cfg_mode16) begin
            // first byte of a pair is only held
            if (!low_held) begin
                held_low = b;
                low_held = 1'b1;
                return 1'b0;
            end
            sample   = {b, held_low};
            low_held = 1'b0;
        end else begin
            // an 8-bit byte drops any held low byte
            sample   = {8'h00, b};
            low_held = 1'b0;
        end
        if (!amp && !att) begin
            res.err = 1'b1;
        end else if (cfg_mode16) begin
            res.word = scale_wide(sample, cfg_level, amp);
        end else begin
            res.word = scale_narrow(sample[7:0], cfg_level, amp);
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // driving and checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // send one byte; always entered and left at a rising edge
    task automatic send_byte(input logic [7:0] b);
        int unsigned  gap;
        t_scaled_word res;
        gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        // byte taken at this edge
        if (predict_word(b, res)) scaled_word_q.push_back(res);
    endtask

    // little-endian pair, low byte first
    task automatic send_sample(input logic [15:0] s);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
    endtask

    // stop sending, let every expected word arrive and the pipe settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (scaled_word_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            abvs_pkg::CFG_SIXTEEN_BIT: cfg_mode16 = val[0];
            abvs_pkg::CFG_VOLUME_LVL:  cfg_level  = val;
            abvs_pkg::CFG_VOLUME_MAX:  cfg_max    = val;
            abvs_pkg::CFG_VOLUME_MIN:  cfg_min    = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_volume(input logic [3:0] lvl, input logic [3:0] vmax,
                              input logic [3:0] vmin);
        write_reg(abvs_pkg::CFG_VOLUME_LVL, lvl);
        write_reg(abvs_pkg::CFG_VOLUME_MAX, vmax);
        write_reg(abvs_pkg::CFG_VOLUME_MIN, vmin);
    endtask

    // receiver: random stall before each word, none while sink_steady is set
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // compare every accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_scaled_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (scaled_word_q.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_m_tdata), 0);
            end else begin
                want = scaled_word_q.pop_front();
                if (o_m_tdata !== want.word) begin
                    report_mismatch("sample_word", 32'(o_m_tdata), 32'(want.word));
                end
                if (o_m_tuser !== want.err) begin
                    report_mismatch("volume_error", 32'(o_m_tuser), 32'(want.err));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // reset settings: 16-bit, unity gain, both signed extremes
    task automatic test_default_unity();
        send_sample(16'h8000);
        send_sample(16'h7fff);
    endtask

    // 16-bit amplification incl. negative saturation and the exact 0x8000 product
    task automatic test_wide_amplify();
        wait_idle();
        set_volume(4'd15, 4'd15, 4'd0);
        send_sample(16'hffff);
        send_sample(16'hf000);
        wait_idle();
        write_reg(abvs_pkg::CFG_VOLUME_LVL, 4'd6);
        send_sample(16'hc000);
    endtask

    // 16-bit attenuation with round-up, deepest and shallowest steps
    task automatic test_wide_attenuate();
        wait_idle();
        write_reg(abvs_pkg::CFG_VOLUME_LVL, 4'd4);
        send_sample(16'hfffe);
        wait_idle();
        write_reg(abvs_pkg::CFG_VOLUME_LVL, 4'd1);
        send_sample(16'h0003);
    endtask

    // 8-bit samples: both saturations, zero level, attenuated negative
    task automatic test_narrow_samples();
        wait_idle();
        write_reg(abvs_pkg::CFG_SIXTEEN_BIT, 4'd0);
        set_volume(4'd15, 4'd15, 4'd0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        wait_idle();
        write_reg(abvs_pkg::CFG_VOLUME_LVL, 4'd1);
        send_byte(8'h01);
    endtask

    // step above max and step not above min both flag an error
    task automatic test_rejected_volume();
        wait_idle();
        set_volume(4'd10, 4'd9, 4'd0);
        send_byte(8'h55);
        wait_idle();
        write_reg(abvs_pkg::CFG_SIXTEEN_BIT, 4'd1);
        set_volume(4'd2, 4'd9, 4'd2);
        send_sample(16'h1234);
    endtask

    // held low byte dropped by an 8-bit byte, then fresh pairing in 16-bit
    task automatic test_mode_switch();
        wait_idle();
        set_volume(4'd5, 4'd9, 4'd0);
        send_byte(8'ha5);
        wait_idle();
        write_reg(abvs_pkg::CFG_SIXTEEN_BIT, 4'd0);
        send_byte(8'h3c);
        wait_idle();
        write_reg(abvs_pkg::CFG_SIXTEEN_BIT, 4'd1);
        send_sample(16'h8001);
    endtask

    // ---------------------------------------------------------------
    // random phases
    // ---------------------------------------------------------------

    // volume step biased toward the rule edges
    function automatic int unsigned pick_step();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4;
            2: return 5;
            3: return 15;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // data byte biased toward sign and saturation edges
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h7f;
            3: return 8'h80;
            4: return 8'h81;
            5: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_phases();
        int unsigned phase, n, lvl, vmax, vmin;
        logic        mode;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            mode = 1'($urandom_range(0, 1));
            lvl  = pick_step();
            vmax = pick_step();
            vmin = pick_step();
            // most phases get an accepted step, the rest land wherever
            if ($urandom_range(0, 4) != 0) begin
                if (lvl > 4) begin
                    vmax = $urandom_range(lvl, 15);
                end else if (lvl > 0) begin
                    vmin = $urandom_range(0, lvl - 1);
                end
            end
            // upper data bits of the mode write are don't-care
            write_reg(abvs_pkg::CFG_SIXTEEN_BIT, {3'($urandom_range(0, 7)), mode});
            set_volume(4'(lvl), 4'(vmax), 4'(vmin));
            send_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) send_byte(pick_data());
        end
        send_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_unity();
        test_wide_amplify();
        test_wide_attenuate();
        test_narrow_samples();
        test_rejected_volume();
        test_mode_switch();
        test_random_phases();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
